@@ rtl/core/tanh_pkg.sv @@
// Shared types and constants for the tanh activation unit.
// Depends on nothing; every other file in rtl/core but tanh_chan_if imports it.
package tanh_pkg;

   localparam int unsigned TERMS      = 13;
   localparam int unsigned POW_STAGES = 16;
   localparam int unsigned DIV_STAGES = 16;
   localparam int unsigned QUO_BITS   = 31;

   localparam logic [31:0] Q31_ONE   = 32'h8000_0000;
   localparam logic [31:0] ROUND_BIT = 32'h0001_0000;

   // e^-1 in Q1.31, built by the same truncated series as the datapath
   function automatic logic [31:0] exp_neg_one();
      logic [63:0]        t;
      logic signed [63:0] s;
      t = 64'd1 << 31;
      s = 64'sd1 <<< 31;
      for (int k = 1; k <= 13; k++) begin
         t = t / 64'(k);
         if ((k % 2) == 1) begin
            s = s - $signed(t);
         end else begin
            s = s + $signed(t);
         end
      end
      return s[31:0];
   endfunction

   localparam logic [31:0] E1 = exp_neg_one();

   typedef struct packed {
      logic               neg;
      logic               last;
      logic [4:0]         cnt;
      logic [10:0]        frac;
      logic [31:0]        term;
      logic [31:0]        prod;
      logic [31:0]        quo;
      logic signed [33:0] sum;
   } exp_lane_type;

   typedef struct packed {
      logic        neg;
      logic        last;
      logic [4:0]  cnt;
      logic [31:0] u;
   } pow_lane_type;

   typedef struct packed {
      logic        neg;
      logic        last;
      logic [33:0] rem;
      logic [32:0] dvs;
      logic [30:0] quo;
   } div_lane_type;

endpackage

@@ rtl/core/tanh_chan_if.sv @@
// Handshake channels of the tanh activation unit: request, response, csr.
// Depends on nothing.
interface tanh_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] operand;
   logic               last;
   modport source (output valid, output operand, output last, input ready);
   modport sink   (input valid, input operand, input last, output ready);
endinterface

interface tanh_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] value;
   logic               last_out;
   modport source (output valid, output value, output last_out, input ready);
   modport sink   (input valid, input value, input last_out, output ready);
endinterface

interface tanh_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/tanh_activation_unit.sv @@
// Top level of the tanh activation unit: input stage, series, divider, output.
// Depends on tanh_pkg, tanh_chan_if and the tanh_* stage modules.
//
// Usage:
//   req_ch carries one Q4.12 activation word (operand, last) per handshake.
//   rsp_ch returns one Q2.14 word (value, last_out) for each request word,
//   in order: tanh(x) when mode is 0, 1 - tanh(x)^2 when mode is 1.
//   csr_ch writes the mode bit; it is always ready. Write it only while no
//   words are in flight.
// Timing:
//   A fixed pipeline of 75 register stages: one input stage, 13 Taylor terms
//   of three stages each (multiply, reciprocal multiply, correction), 16
//   conditional multiplies by e^-1, one divider setup stage, 16 divider
//   slices producing the 31 quotient bits, and two result stages.
//   Throughput is one word per cycle while no result is held by the receiver.
// Flow control:
//   All stages advance together. When a result sits in the output register
//   and the receiver holds ready low, the whole pipe freezes and req ready
//   drops; nothing is lost or repeated.
// Reset:
//   Clears every valid bit and sets mode to forward tanh.
module tanh_activation_unit
   import tanh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   tanh_req_if.sink   req_ch,
   tanh_rsp_if.source rsp_ch,
   tanh_csr_if.sink   csr_ch
);

   logic mode_ff;
   logic en;

   // input stage
   logic         in_valid_ff;
   exp_lane_type in_lane_ff, in_lane_in;
   logic [16:0]  abs_val;

   logic         exp_valid [0:TERMS];
   exp_lane_type exp_lane  [0:TERMS];
   logic         pow_valid [0:POW_STAGES];
   pow_lane_type pow_lane  [0:POW_STAGES];
   logic         div_valid [0:DIV_STAGES];
   div_lane_type div_lane  [0:DIV_STAGES];

   logic         prep_valid_ff;
   div_lane_type prep_ff, prep_in;
   logic [31:0]  u_clamp;

   // advance unless a finished word is held by the receiver
   assign en = ~(rsp_ch.valid & ~rsp_ch.ready);
   assign req_ch.ready = en;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         mode_ff <= csr_ch.data[0];
      end
   end

   // split |x| into whole units of 0.5 and the fraction below
   always_comb begin
      abs_val = req_ch.operand[15] ? (17'h10000 - {1'b0, req_ch.operand})
                                   : {1'b0, req_ch.operand};
      in_lane_in      = '0;
      in_lane_in.neg  = req_ch.operand[15];
      in_lane_in.last = req_ch.last;
      in_lane_in.cnt  = abs_val[15:11];
      in_lane_in.frac = abs_val[10:0];
      in_lane_in.term = Q31_ONE;
      in_lane_in.sum  = $signed({2'b00, Q31_ONE});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_lane_ff <= in_lane_in;
      end
   end

   assign exp_valid[0] = in_valid_ff;
   assign exp_lane[0]  = in_lane_ff;

   for (genvar k = 0; k < TERMS; k++) begin : g_term
      tanh_term #(.K(k + 1)) u_term (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (exp_valid[k]),
         .lane_in   (exp_lane[k]),
         .valid_out (exp_valid[k+1]),
         .lane_out  (exp_lane[k+1])
      );
   end

   // drop a negative series sum to zero
   assign pow_valid[0]     = exp_valid[TERMS];
   assign pow_lane[0].neg  = exp_lane[TERMS].neg;
   assign pow_lane[0].last = exp_lane[TERMS].last;
   assign pow_lane[0].cnt  = exp_lane[TERMS].cnt;
   assign pow_lane[0].u    = exp_lane[TERMS].sum[33] ? 32'd0 : exp_lane[TERMS].sum[31:0];

   for (genvar i = 0; i < POW_STAGES; i++) begin : g_pow
      tanh_pow #(.IDX(i)) u_pow (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (pow_valid[i]),
         .lane_in   (pow_lane[i]),
         .valid_out (pow_valid[i+1]),
         .lane_out  (pow_lane[i+1])
      );
   end

   // divider setup: remainder 1 - u, divisor 1 + u
   always_comb begin
      u_clamp = (pow_lane[POW_STAGES].u > Q31_ONE) ? Q31_ONE : pow_lane[POW_STAGES].u;
      prep_in.neg  = pow_lane[POW_STAGES].neg;
      prep_in.last = pow_lane[POW_STAGES].last;
      prep_in.rem  = {2'b00, Q31_ONE - u_clamp};
      prep_in.dvs  = {1'b0, Q31_ONE} + {1'b0, u_clamp};
      prep_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (en) begin
         prep_valid_ff <= pow_valid[POW_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff <= prep_in;
      end
   end

   assign div_valid[0] = prep_valid_ff;
   assign div_lane[0]  = prep_ff;

   // two quotient bits per slice, one in the last
   for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
      localparam int unsigned STEPS = (d == DIV_STAGES - 1) ?
         (QUO_BITS - 2 * (DIV_STAGES - 1)) : 2;
      tanh_div #(.STEPS(STEPS)) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (div_valid[d]),
         .lane_in   (div_lane[d]),
         .valid_out (div_valid[d+1]),
         .lane_out  (div_lane[d+1])
      );
   end

   tanh_result u_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .mode      (mode_ff),
      .valid_in  (div_valid[DIV_STAGES]),
      .neg_in    (div_lane[DIV_STAGES].neg),
      .last_in   (div_lane[DIV_STAGES].last),
      .tq_in     (div_lane[DIV_STAGES].quo),
      .valid_out (rsp_ch.valid),
      .value_out (rsp_ch.value),
      .last_out  (rsp_ch.last_out)
   );

endmodule

@@ rtl/core/tanh_term.sv @@
// One Taylor term of e^-z: multiply, divide by K via reciprocal, correct.
// Depends on tanh_pkg.
module tanh_term
   import tanh_pkg::*;
#(
   parameter int unsigned K = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         valid_in,
   input  exp_lane_type lane_in,
   output logic         valid_out,
   output exp_lane_type lane_out
);

   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
   localparam logic [3:0]  KV    = 4'(K);

   logic [2:0]   valid_ff;
   exp_lane_type l1_ff, l1_in;
   exp_lane_type l2_ff, l2_in;
   exp_lane_type l3_ff, l3_in;
   logic [42:0]  tmul;
   logic [64:0]  qmul;
   logic [35:0]  back;
   logic [31:0]  rem;
   logic [31:0]  q;

   always_comb begin
      tmul = {11'd0, lane_in.term} * {32'd0, lane_in.frac};
      l1_in = lane_in;
      l1_in.prod = tmul[42:11];
   end

   always_comb begin
      qmul = {33'd0, l1_ff.prod} * {32'd0, RECIP};
      l2_in = l1_ff;
      l2_in.quo = qmul[63:32];
   end

   // reciprocal estimate is low by at most one
   always_comb begin
      back = l2_ff.quo * KV;
      rem = l2_ff.prod - back[31:0];
      q = (rem >= 32'(K)) ? l2_ff.quo + 32'd1 : l2_ff.quo;
      l3_in = l2_ff;
      l3_in.term = q;
      if ((K % 2) == 1) begin
         l3_in.sum = l2_ff.sum - $signed({2'b00, q});
      end else begin
         l3_in.sum = l2_ff.sum + $signed({2'b00, q});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l1_ff <= l1_in;
         l2_ff <= l2_in;
         l3_ff <= l3_in;
      end
   end

   assign valid_out = valid_ff[2];
   assign lane_out  = l3_ff;

endmodule

@@ rtl/core/tanh_pow.sv @@
// One step of the integer-power chain: multiply by e^-1 when the count allows.
// Depends on tanh_pkg.
module tanh_pow
   import tanh_pkg::*;
#(
   parameter int unsigned IDX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         valid_in,
   input  pow_lane_type lane_in,
   output logic         valid_out,
   output pow_lane_type lane_out
);

   logic         valid_ff;
   pow_lane_type lane_ff, lane_in2;
   logic [63:0]  pmul;

   always_comb begin
      pmul = {32'd0, lane_in.u} * {32'd0, E1};
      lane_in2 = lane_in;
      if (lane_in.cnt > 5'(IDX)) begin
         lane_in2.u = pmul[62:31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in2;
      end
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;

endmodule

@@ rtl/core/tanh_div.sv @@
// Restoring divider slice: STEPS quotient bits per register stage.
// Depends on tanh_pkg.
module tanh_div
   import tanh_pkg::*;
#(
   parameter int unsigned STEPS = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         valid_in,
   input  div_lane_type lane_in,
   output logic         valid_out,
   output div_lane_type lane_out
);

   logic         valid_ff;
   div_lane_type lane_ff, nxt;
   logic [33:0]  r2;

   always_comb begin
      nxt = lane_in;
      r2 = '0;
      for (int j = 0; j < STEPS; j++) begin
         r2 = {nxt.rem[32:0], 1'b0};
         if (r2 >= {1'b0, nxt.dvs}) begin
            nxt.rem = r2 - {1'b0, nxt.dvs};
            nxt.quo = {nxt.quo[29:0], 1'b1};
         end else begin
            nxt.rem = r2;
            nxt.quo = {nxt.quo[29:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= nxt;
      end
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;

endmodule

@@ rtl/core/tanh_out.sv @@
// Result stages: square tanh, then round to Q2.14 for the selected mode.
// Depends on tanh_pkg.
module tanh_result
   import tanh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               mode,
   input  logic               valid_in,
   input  logic               neg_in,
   input  logic               last_in,
   input  logic [30:0]        tq_in,
   output logic               valid_out,
   output logic signed [15:0] value_out,
   output logic               last_out
);

   logic               sq_valid_ff;
   logic               sq_neg_ff;
   logic               sq_last_ff;
   logic [30:0]        sq_tq_ff;
   logic [61:0]        sq_ff, sq_in;
   logic               res_valid_ff;
   logic signed [15:0] res_ff, res_in;
   logic               res_last_ff;
   logic [31:0]        fwd_sum;
   logic [15:0]        fwd_mag;
   logic [31:0]        dval;
   logic [32:0]        dsum;

   assign sq_in = {31'd0, tq_in} * {31'd0, tq_in};

   always_comb begin
      fwd_sum = {1'b0, sq_tq_ff} + ROUND_BIT;
      fwd_mag = {1'b0, fwd_sum[31:17]};
      dval = Q31_ONE - {1'b0, sq_ff[61:31]};
      dsum = {1'b0, dval} + {1'b0, ROUND_BIT};
      if (mode) begin
         res_in = $signed(dsum[32:17]);
      end else if (sq_neg_ff) begin
         res_in = $signed(16'd0 - fwd_mag);
      end else begin
         res_in = $signed(fwd_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff  <= valid_in;
         res_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_neg_ff   <= neg_in;
         sq_last_ff  <= last_in;
         sq_tq_ff    <= tq_in;
         sq_ff       <= sq_in;
         res_ff      <= res_in;
         res_last_ff <= sq_last_ff;
      end
   end

   assign valid_out = res_valid_ff;
   assign value_out = res_ff;
   assign last_out  = res_last_ff;

endmodule

@@ dv/tanh_activation_unit_tb.sv @@
// Testbench for tanh_activation_unit: streams Q4.12 words in both modes and
// checks every Q2.14 result against an in-bench bit-exact predictor.
// Depends on tanh_pkg, tanh_chan_if and the RTL of tanh_activation_unit.
`timescale 1ns / 1ps

module tanh_activation_unit_tb;
   import tanh_pkg::*;

   localparam logic [63:0] ONE_Q31    = 64'd1 << 31;
   localparam int          PIPE_DEPTH = 75;

   typedef enum logic [0:0] {MODE_FORWARD = 1'b0, MODE_DERIV = 1'b1} mode_type;

   typedef struct packed {
      logic signed [15:0] value;
      logic               last_out;
   } result_type;

   logic clock;
   logic reset;

   tanh_req_if req_ch ();
   tanh_rsp_if rsp_ch ();
   tanh_csr_if csr_ch ();

   tanh_activation_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // mode as the unit sees it, tracked on each accepted csr write
   mode_type   cur_mode;
   result_type expected_q[$];
   int         error_count;
   int         stall_hold;   // cycles the receiver must still hold off
   bit         steady;       // suppress random idling on both sides

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------
   // Predictor: e^-z by truncated alternating series, Q1.31 in and out
   // ---------------------------------------------------------------------
   function automatic logic [63:0] exp_series(logic [63:0] z);
      logic [63:0]        term;
      logic signed [63:0] acc;
      term = ONE_Q31;
      acc  = $signed(ONE_Q31);
      for (int k = 1; k <= 13; k++) begin
         term = ((term * z) >> 31) / 64'(k);
         if (k % 2 == 1) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return acc;
   endfunction

   // tanh(|x|) in Q1.31 for magnitude mag in Q4.12 (0..32768)
   function automatic logic [63:0] tanh_mag(logic [31:0] mag);
      logic [63:0] u;
      logic [63:0] e1;
      u  = exp_series(64'(mag & 32'd2047) << 20);
      e1 = exp_series(ONE_Q31);
      for (int i = 0; i < int'(mag >> 11); i++) begin
         u = (u * e1) >> 31;
      end
      if (u > ONE_Q31) begin
         u = ONE_Q31;
      end
      return ((ONE_Q31 - u) << 31) / (ONE_Q31 + u);
   endfunction

   function automatic logic [15:0] tanh_predict(logic [15:0] x, mode_type m);
      logic        neg;
      logic [31:0] mag;
      logic [63:0] tq;
      logic [63:0] sq;
      logic [63:0] d;
      logic [31:0] v;
      neg = x[15];
      mag = neg ? (32'h10000 - 32'(x)) : 32'(x);
      tq  = tanh_mag(mag);
      if (m == MODE_FORWARD) begin
         v = 32'((tq + (64'd1 << 16)) >> 17);
         return neg ? 16'(32'h10000 - v) : v[15:0];
      end
      sq = (tq * tq) >> 31;
      d  = (sq >= ONE_Q31) ? 64'd0 : (ONE_Q31 - sq);
      return 16'((d + (64'd1 << 16)) >> 17);
   endfunction

   // ---------------------------------------------------------------------
   // Shared helpers
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) begin
         return 0;
      end
      if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 30);
   endfunction

   task automatic report(string field, int got, int want);
      $display("%0t ERROR %s: got %0d, predicted %0d", $realtime, field, got, want);
      error_count++;
   endtask

   // Offer one word; keep valid high across back-to-back words.
   task automatic send_word(logic [15:0] x, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.operand <= x;
      req_ch.last    <= last;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      expected_q.push_back('{value: tanh_predict(x, cur_mode), last_out: last});
   endtask

   // Drain the pipe, then write mode while the unit is idle.
   task automatic write_mode(mode_type m);
      req_ch.valid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= m;
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      cur_mode = m;
   endtask

   // Random operand: mostly the interesting |x| < 4 band, some full range, some near zero.
   function automatic logic [15:0] rand_operand();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         return 16'($signed($urandom_range(0, 32767)) - 16384);
      end
      if (r < 8) begin
         return 16'($urandom_range(0, 65535));
      end
      return 16'($signed($urandom_range(0, 511)) - 256);
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus a long forced hold-off on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_hold   <= stall_hold - 1;
      end else begin
         rsp_ch.ready <= steady ? 1'b1 : (pick_gap() == 0);
      end
   end

   // Checker: compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            report("unexpected word, value", rsp_ch.value, 0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_ch.value !== want.value) begin
               report("value", rsp_ch.value, want.value);
            end
            if (rsp_ch.last_out !== want.last_out) begin
               report("last_out", rsp_ch.last_out, want.last_out);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Field extremes, zero, breakpoints of the e^-1 power chain, saturation.
   task automatic test_edges();
      logic [15:0] pts[$];
      pts = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
              16'h07FF, 16'h0800, 16'hF800, 16'h1000, 16'hEFFF, 16'h3000,
              16'h5555, 16'hAAAA, 16'h0100, 16'hFF00};
      foreach (pts[i]) begin
         send_word(pts[i], i[0]);
      end
   endtask

   task automatic test_mode(mode_type m, int count);
      write_mode(m);
      test_edges();
      for (int i = 0; i < count; i++) begin
         send_word(rand_operand(), $urandom_range(0, 7) == 0);
      end
   endtask

   // Hold the receiver off long enough to fill the pipe and stall the input.
   task automatic test_backpressure();
      steady = 1'b1;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      stall_hold = 2 * PIPE_DEPTH;
      for (int i = 0; i < 200; i++) begin
         send_word(rand_operand(), i == 199);
      end
      steady = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.operand = '0;
      req_ch.last    = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.data    = '0;
      rsp_ch.ready   = 1'b0;
      cur_mode       = MODE_FORWARD;
      error_count    = 0;
      stall_hold     = 0;
      steady         = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of mode first, no write
      test_edges();
      test_mode(MODE_DERIV, 300);
      test_backpressure();
      test_mode(MODE_FORWARD, 300);
      test_mode(MODE_DERIV, 150);

      req_ch.valid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("tanh_activation_unit: match");
      end else begin
         $display("tanh_activation_unit: mismatch");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #5ms;
      $display("tanh_activation_unit: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/tanh_pkg.sv
rtl/core/tanh_chan_if.sv
rtl/core/tanh_term.sv
rtl/core/tanh_pow.sv
rtl/core/tanh_div.sv
rtl/core/tanh_out.sv
rtl/core/tanh_activation_unit.sv
dv/tanh_activation_unit_tb.sv
